FILE: hw/rtl/mss_pkg.sv
// Shared types and constants of the MIDI step sequencer.
package mss_pkg;

    localparam int MAX_STEPS = 16;
    localparam int IDX_W     = $clog2(MAX_STEPS);
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;
    localparam int PKT_W     = 28;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_STEPS       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIDI_CHANNEL    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NOTE_OFF_STATUS = 2'd2;

    localparam logic [4:0] NUM_STEPS_RST       = 5'd16;
    localparam logic [3:0] MIDI_CHANNEL_RST    = 4'd0;
    localparam logic [7:0] NOTE_OFF_STATUS_RST = 8'd128;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef struct packed {
        logic       glide;
        logic [7:0] velocity;
        logic [7:0] note;
        logic [7:0] status;
    } step_t;

    typedef struct packed {
        logic             data_we;
        logic             glide_we;
        logic [IDX_W-1:0] addr;
        step_t            step;
    } tbl_wr_t;

    // status in the lowest bits, velocity in the highest
    typedef struct packed {
        logic [7:0] velocity;
        logic [7:0] note;
        logic [3:0] channel;
        logic [7:0] status;
    } pkt_t;

endpackage

FILE: hw/rtl/mss_step_table.sv
// Step table: one write port, two registered read ports, valid bits for the reset value.
module mss_step_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mss_pkg::tbl_wr_t            wr,
    input  logic                        rd_en,
    input  logic [mss_pkg::IDX_W-1:0]   rd_addr_a,
    input  logic [mss_pkg::IDX_W-1:0]   rd_addr_b,
    output mss_pkg::step_t              rd_a,
    output mss_pkg::step_t              rd_b
);

    logic [23:0] data_mem  [mss_pkg::MAX_STEPS];
    logic        glide_mem [mss_pkg::MAX_STEPS];

    logic [mss_pkg::MAX_STEPS-1:0] data_vld_reg;
    logic [mss_pkg::MAX_STEPS-1:0] glide_vld_reg;

    logic [23:0] a_data_reg;
    logic [23:0] b_data_reg;
    logic        a_glide_reg;
    logic        b_glide_reg;
    logic        a_dvld_reg;
    logic        b_dvld_reg;
    logic        a_gvld_reg;
    logic        b_gvld_reg;

    always_ff @(posedge aclk) begin
        if (wr.data_we) begin
            data_mem[wr.addr] <= {wr.step.velocity, wr.step.note, wr.step.status};
        end
        if (wr.glide_we) begin
            glide_mem[wr.addr] <= wr.step.glide;
        end
        if (rd_en) begin
            a_data_reg  <= data_mem[rd_addr_a];
            b_data_reg  <= data_mem[rd_addr_b];
            a_glide_reg <= glide_mem[rd_addr_a];
            b_glide_reg <= glide_mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_vld_reg  <= '0;
            glide_vld_reg <= '0;
            a_dvld_reg    <= 1'b0;
            b_dvld_reg    <= 1'b0;
            a_gvld_reg    <= 1'b0;
            b_gvld_reg    <= 1'b0;
        end else begin
            if (wr.data_we) begin
                data_vld_reg[wr.addr] <= 1'b1;
            end
            if (wr.glide_we) begin
                glide_vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                a_dvld_reg <= data_vld_reg[rd_addr_a];
                b_dvld_reg <= data_vld_reg[rd_addr_b];
                a_gvld_reg <= glide_vld_reg[rd_addr_a];
                b_gvld_reg <= glide_vld_reg[rd_addr_b];
            end
        end
    end

    // never-written entries read as zero
    always_comb begin
        rd_a.status   = a_dvld_reg ? a_data_reg[7:0]   : 8'd0;
        rd_a.note     = a_dvld_reg ? a_data_reg[15:8]  : 8'd0;
        rd_a.velocity = a_dvld_reg ? a_data_reg[23:16] : 8'd0;
        rd_a.glide    = a_gvld_reg ? a_glide_reg       : 1'b0;
        rd_b.status   = b_dvld_reg ? b_data_reg[7:0]   : 8'd0;
        rd_b.note     = b_dvld_reg ? b_data_reg[15:8]  : 8'd0;
        rd_b.velocity = b_dvld_reg ? b_data_reg[23:16] : 8'd0;
        rd_b.glide    = b_gvld_reg ? b_glide_reg       : 1'b0;
    end

endmodule

FILE: hw/rtl/midi_step_sequencer.sv
// Looping MIDI step sequencer with glide: top level.
//
//  Channel   Direction  Payload                                          Framing
//  s_axis    in         tdata: step/rx/status/note/velocity/glide        tuser = func
//  m_axis    out        tdata: status/channel/note/velocity              tlast on 2nd packet
//  cfg       in         cfg_addr selects register, cfg_wdata value       write on cfg_we
//
// A request is registered on acceptance together with the table reads for the
// current and previous step; for a tick, both packets are then formed and loaded
// into the output register once it is free. A tick therefore occupies the single
// result port with two packets, and a load passes with no result.
// Reset is synchronous; the table reads as zero through valid bits, no clearing
// pass. A stalled output holds its packet while a further request is taken.
module midi_step_sequencer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [3:0] step_index, [4] rx_valid, [12:5] step_status, [20:13] step_note,
    // [28:21] step_velocity, [29] step_glide, [31:30] zero
    input  logic [mss_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // [0] func
    input  logic [0:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] pkt_status, [11:8] pkt_channel, [19:12] pkt_note,
    // [27:20] pkt_velocity, [31:28] zero
    output logic [mss_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_we,
    input  logic [mss_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [mss_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int IDX_W = mss_pkg::IDX_W;
    localparam int CNT_W = mss_pkg::CNT_W;

    // configuration
    logic [4:0] num_steps_reg;
    logic [3:0] midi_channel_reg;
    logic [7:0] note_off_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_steps_reg       <= mss_pkg::NUM_STEPS_RST;
            midi_channel_reg    <= mss_pkg::MIDI_CHANNEL_RST;
            note_off_status_reg <= mss_pkg::NOTE_OFF_STATUS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                mss_pkg::REG_NUM_STEPS:       num_steps_reg       <= cfg_wdata[4:0];
                mss_pkg::REG_MIDI_CHANNEL:    midi_channel_reg    <= cfg_wdata[3:0];
                mss_pkg::REG_NOTE_OFF_STATUS: note_off_status_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input fields
    logic [3:0] in_index;
    logic       in_rxv;
    logic       in_load;
    logic       in_glide;
    logic [7:0] in_status;
    logic [7:0] in_note;
    logic [7:0] in_velocity;

    assign in_index    = s_axis_tdata[3:0];
    assign in_rxv      = s_axis_tdata[4];
    assign in_status   = s_axis_tdata[12:5];
    assign in_note     = s_axis_tdata[20:13];
    assign in_velocity = s_axis_tdata[28:21];
    assign in_glide    = s_axis_tdata[29];
    assign in_load     = (s_axis_tuser[0] == mss_pkg::FUNC_LOAD);

    // step counter
    logic [IDX_W-1:0] step_cnt_reg;
    logic [IDX_W-1:0] step_cnt_next;
    logic [CNT_W-1:0] act_cnt;
    logic [CNT_W-1:0] cnt_inc;
    logic [IDX_W-1:0] prv_idx;

    always_comb begin
        if (num_steps_reg == 5'd0) begin
            act_cnt = CNT_W'(1);
        end else if (32'(num_steps_reg) > 32'(mss_pkg::MAX_STEPS)) begin
            act_cnt = CNT_W'(mss_pkg::MAX_STEPS);
        end else begin
            act_cnt = CNT_W'(num_steps_reg);
        end
        prv_idx = (step_cnt_reg == '0) ? IDX_W'(act_cnt - CNT_W'(1))
                                       : step_cnt_reg - IDX_W'(1);
        cnt_inc = CNT_W'(step_cnt_reg) + CNT_W'(1);
        // also wraps a counter left beyond a lowered step count
        step_cnt_next = (cnt_inc >= act_cnt) ? '0 : IDX_W'(cnt_inc);
    end

    // handshake
    logic s_accept;
    logic s1_valid_reg;
    logic s1_load_reg;
    logic s1_move;
    logic out_valid_reg;
    logic out_last_reg;
    logic out_free;

    assign out_free      = !out_valid_reg || (m_axis_tready && out_last_reg);
    assign s1_move       = s1_valid_reg && (s1_load_reg || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cnt_reg <= '0;
        end else if (s_accept && !in_load) begin
            step_cnt_reg <= step_cnt_next;
        end
    end

    // table writes: a tick may overwrite the current step, a load writes one whole step
    mss_pkg::tbl_wr_t tbl_wr;
    mss_pkg::step_t   rd_cur;
    mss_pkg::step_t   rd_prv;

    always_comb begin
        tbl_wr.step.status   = in_status;
        tbl_wr.step.note     = in_note;
        tbl_wr.step.velocity = in_velocity;
        tbl_wr.step.glide    = in_glide;
        if (in_load) begin
            tbl_wr.addr     = IDX_W'(in_index);
            tbl_wr.data_we  = s_accept && (32'(in_index) < 32'(mss_pkg::MAX_STEPS));
            tbl_wr.glide_we = tbl_wr.data_we;
        end else begin
            tbl_wr.addr     = step_cnt_reg;
            tbl_wr.data_we  = s_accept && in_rxv;
            tbl_wr.glide_we = 1'b0;
        end
    end

    mss_step_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (tbl_wr),
        .rd_en     (s_accept),
        .rd_addr_a (step_cnt_reg),
        .rd_addr_b (prv_idx),
        .rd_a      (rd_cur),
        .rd_b      (rd_prv)
    );

    // request register; the reads above see the table before this request's write
    logic           s1_rxv_reg;
    logic           s1_same_reg;
    mss_pkg::step_t s1_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_load_reg  <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
            s1_load_reg  <= in_load;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_rxv_reg           <= in_rxv;
            s1_same_reg          <= (prv_idx == step_cnt_reg);
            s1_step_reg.status   <= in_status;
            s1_step_reg.note     <= in_note;
            s1_step_reg.velocity <= in_velocity;
            s1_step_reg.glide    <= in_glide;
        end
    end

    // packet formation
    mss_pkg::step_t cur_step;
    mss_pkg::step_t prv_step;
    mss_pkg::pkt_t  pkt_cur;
    mss_pkg::pkt_t  pkt_off;
    mss_pkg::pkt_t  pkt_first;
    mss_pkg::pkt_t  pkt_second;

    always_comb begin
        cur_step = rd_cur;
        if (s1_rxv_reg) begin
            cur_step.status   = s1_step_reg.status;
            cur_step.note     = s1_step_reg.note;
            cur_step.velocity = s1_step_reg.velocity;
        end
        // single active step: previous is the current one after overwrite
        prv_step = s1_same_reg ? cur_step : rd_prv;

        pkt_cur.status   = cur_step.status;
        pkt_cur.channel  = midi_channel_reg;
        pkt_cur.note     = cur_step.note;
        pkt_cur.velocity = cur_step.velocity;
        pkt_off.status   = note_off_status_reg;
        pkt_off.channel  = midi_channel_reg;
        pkt_off.note     = prv_step.note;
        pkt_off.velocity = prv_step.velocity;

        // glide on the previous step: new note sounds before the old one stops
        pkt_first  = prv_step.glide ? pkt_cur : pkt_off;
        pkt_second = prv_step.glide ? pkt_off : pkt_cur;
    end

    // output register with a holding slot for the second packet
    mss_pkg::pkt_t out_pkt_reg;
    mss_pkg::pkt_t hold_pkt_reg;
    logic          out_take;

    assign out_take = s1_move && !s1_load_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else if (out_take) begin
            out_valid_reg <= 1'b1;
            out_last_reg  <= 1'b0;
        end else if (out_valid_reg && m_axis_tready) begin
            if (out_last_reg) begin
                out_valid_reg <= 1'b0;
            end else begin
                out_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            out_pkt_reg  <= pkt_first;
            hold_pkt_reg <= pkt_second;
        end else if (out_valid_reg && m_axis_tready && !out_last_reg) begin
            out_pkt_reg <= hold_pkt_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(mss_pkg::M_TDATA_W - mss_pkg::PKT_W)'(0), out_pkt_reg};

endmodule

FILE: hw/rtl/mss_checker.sv
// Port-level checks of the MIDI step sequencer, bound to the top level.
module mss_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [mss_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input logic                              m_axis_tlast
);

    logic first_pkt_done;

    assign first_pkt_done = m_axis_tvalid && m_axis_tready && !m_axis_tlast;

    // stalled packet is held
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // the second packet of a tick follows straight after the first
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        first_pkt_done |=> m_axis_tvalid && m_axis_tlast)
        else $error("second packet of a tick missing");

    // both packets of a tick carry the same channel
    a_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        first_pkt_done |=> m_axis_tdata[11:8] == $past(m_axis_tdata[11:8]))
        else $error("channel differs within a tick");

    // reset leaves no result pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind midi_step_sequencer mss_checker u_mss_checker (.*);
